>>> src/dfs_topological_order_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depth-first topological order block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DFS_TOPOLOGICAL_ORDER_ASSERT_SVH
`define DFS_TOPOLOGICAL_ORDER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define DFS_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A consequence that holds in the same cycle as its cause.
`define DFS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A consequence that holds in the cycle after its cause.
`define DFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/dfs_topo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_topo_pkg
// Types, constants and helper functions shared by the topological order block.
// ----------------------------------------------------------------------------
package dfs_topo_pkg;

	localparam int NODE_W = 4;
	localparam int ROW_W  = 16;
	localparam int CFG_W  = 5;

	localparam logic [CFG_W-1:0] NODE_COUNT_RST = 5'd16;

	// Controller states.
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FIND,
		ST_READ,
		ST_EVAL,
		ST_EMIT
	} dfs_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_row;
		logic begin_walk;
		logic start_push;
		logic rd_issue;
		logic push;
		logic pop;
		logic emit_init;
		logic emit;
	} dfs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic row_in_range;
		logic row_is_last;
		logic start_found;
		logic cand_found;
		logic depth_one;
		logic emit_last;
		logic out_free;
	} dfs_stat_t;

	// Index of the lowest set bit; zero when no bit is set.
	function automatic logic [NODE_W-1:0] first_set(input logic [ROW_W-1:0] m);
		logic [NODE_W-1:0] r;
		r = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = i[NODE_W-1:0];
			end
		end
		return r;
	endfunction

endpackage

>>> src/dfs_topo_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_topo_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dfs_topo_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/dfs_topo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_topo_ctrl
// Controller for row loading, the depth-first walk and the result output.
// ----------------------------------------------------------------------------
`include "dfs_topological_order_assert.svh"

module dfs_topo_ctrl
	import dfs_topo_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  dfs_stat_t stat,
	output dfs_cmd_t  cmd
);

	dfs_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid && stat.row_in_range) begin
					cmd.load_row = 1'b1;
					if (stat.row_is_last) begin
						cmd.begin_walk = 1'b1;
						state_d        = ST_FIND;
					end
				end
			end
			ST_FIND: begin
				if (stat.start_found) begin
					cmd.start_push = 1'b1;
					state_d        = ST_READ;
				end else begin
					cmd.emit_init = 1'b1;
					state_d       = ST_EMIT;
				end
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_EVAL;
			end
			ST_EVAL: begin
				if (stat.cand_found) begin
					cmd.push = 1'b1;
					state_d  = ST_READ;
				end else begin
					cmd.pop = 1'b1;
					state_d = stat.depth_one ? ST_FIND : ST_READ;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.emit_last) begin
						state_d = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// The adjacency data is only evaluated in the cycle after its read.
	`DFS_ASSERT_IMPLY(a_eval_after_read, state_q == ST_EVAL, $past(state_q) == ST_READ, "eval without read")
	// A walk only starts from an accepted word.
	`DFS_ASSERT_IMPLY(a_walk_on_accept, cmd.begin_walk, s_tvalid && s_tready, "walk without word")
	// After the final result is loaded the block returns to loading rows.
	`DFS_ASSERT_NEXT(a_emit_done, cmd.emit && stat.emit_last, state_q == ST_LOAD, "emit did not end")

endmodule

>>> src/dfs_topo_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_topo_dp
// Datapath: adjacency RAM, visited marks, walk stack, finished order and
// the output register.
// ----------------------------------------------------------------------------
`include "dfs_topological_order_assert.svh"

module dfs_topo_dp
	import dfs_topo_pkg::*;
#(
	parameter int NODES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic [NODE_W-1:0] row_index,
	input  logic [ROW_W-1:0]  row_edges,
	input  dfs_cmd_t          cmd,
	output dfs_stat_t         stat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NODE_W-1:0] node_id,
	output logic              last_node
);

	localparam int SW = $clog2(NODES);
	localparam int CW = $clog2(NODES + 1);

	logic [CFG_W-1:0]  node_count_q;
	logic [CFG_W-1:0]  n_eff;
	logic [ROW_W-1:0]  live;
	logic [ROW_W-1:0]  visited_q;
	logic [CW-1:0]     depth_q;
	logic [CW-1:0]     depth_m1;
	logic [CW-1:0]     fin_cnt_q;
	logic [CW-1:0]     emit_q;
	logic              out_valid_q;
	logic [NODE_W-1:0] node_id_q;
	logic              last_node_q;
	logic [NODE_W-1:0] path_q [NODES];
	logic [NODE_W-1:0] fin_q [NODES];
	logic [NODE_W-1:0] top_node;
	logic [ROW_W-1:0]  rd_row;
	logic [ROW_W-1:0]  unvisited;
	logic [ROW_W-1:0]  cand;
	logic [NODE_W-1:0] start_node;
	logic [NODE_W-1:0] cand_node;
	logic              push_room;
	logic              fin_room;

	// Node count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_wen) begin
			node_count_q <= cfg_wdata;
		end
	end

	// Effective node count: zero acts as one, capped at the storage depth.
	always_comb begin
		n_eff = node_count_q;
		if (n_eff == '0) begin
			n_eff = CFG_W'(1);
		end
		if (n_eff > CFG_W'(NODES)) begin
			n_eff = CFG_W'(NODES);
		end
	end

	// Mask of the nodes in use.
	always_comb begin
		for (int j = 0; j < ROW_W; j++) begin
			live[j] = (CFG_W'(j) < n_eff);
		end
	end

	// Adjacency rows.
	dfs_topo_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NODES)
	) u_adj_ram (
		.clk  (clk),
		.we   (cmd.load_row),
		.waddr(row_index[SW-1:0]),
		.wdata(row_edges),
		.re   (cmd.rd_issue),
		.raddr(top_node[SW-1:0]),
		.rdata(rd_row)
	);

	// Stack top, start search and neighbor search.
	assign depth_m1   = depth_q - CW'(1);
	assign top_node   = path_q[depth_m1[SW-1:0]];
	assign unvisited  = live & ~visited_q;
	assign start_node = first_set(unvisited);
	assign cand       = rd_row & live & ~visited_q;
	assign cand_node  = first_set(cand);
	assign push_room  = CFG_W'(depth_q) < n_eff;
	assign fin_room   = CFG_W'(fin_cnt_q) < n_eff;

	// Status to the controller.
	always_comb begin
		stat.row_in_range = {1'b0, row_index} < n_eff;
		stat.row_is_last  = {1'b0, row_index} == (n_eff - CFG_W'(1));
		stat.start_found  = |unvisited;
		stat.cand_found   = |cand;
		stat.depth_one    = depth_q == CW'(1);
		stat.emit_last    = emit_q == '0;
		stat.out_free     = !out_valid_q || out_ready;
	end

	// Walk control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			depth_q   <= '0;
			fin_cnt_q <= '0;
			emit_q    <= '0;
		end else begin
			if (cmd.begin_walk) begin
				visited_q <= '0;
				depth_q   <= '0;
				fin_cnt_q <= '0;
			end
			if (cmd.start_push) begin
				visited_q <= visited_q | (ROW_W'(1) << start_node);
				depth_q   <= CW'(1);
			end
			if (cmd.push) begin
				visited_q <= visited_q | (ROW_W'(1) << cand_node);
				if (push_room) begin
					depth_q <= depth_q + CW'(1);
				end
			end
			if (cmd.pop) begin
				depth_q <= depth_m1;
				if (fin_room) begin
					fin_cnt_q <= fin_cnt_q + CW'(1);
				end
			end
			if (cmd.emit_init) begin
				emit_q <= fin_cnt_q - CW'(1);
			end else if (cmd.emit) begin
				emit_q <= emit_q - CW'(1);
			end
		end
	end

	// Walk stack and finished order storage.
	always_ff @(posedge clk) begin
		if (cmd.start_push) begin
			path_q[0] <= start_node;
		end
		if (cmd.push && push_room) begin
			path_q[depth_q[SW-1:0]] <= cand_node;
		end
		if (cmd.pop && fin_room) begin
			fin_q[fin_cnt_q[SW-1:0]] <= top_node;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload, finished nodes taken newest first.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			node_id_q   <= fin_q[emit_q[SW-1:0]];
			last_node_q <= (emit_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign node_id   = node_id_q;
	assign last_node = last_node_q;

	// The stack never grows beyond the number of nodes.
	`DFS_ASSERT_ALWAYS(a_depth_bound, depth_q <= CW'(NODES), "stack depth out of range")
	// Every visited node is either on the stack or finished.
	`DFS_ASSERT_ALWAYS(a_visit_balance, $countones(visited_q) == (32'(depth_q) + 32'(fin_cnt_q)), "visited count mismatch")
	// A result is only loaded into a free output register.
	`DFS_ASSERT_IMPLY(a_emit_free, cmd.emit, !out_valid_q || out_ready, "output overwritten")

endmodule

>>> src/dfs_topological_order.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_topological_order
// Depth-first topological order of a directed graph loaded as adjacency rows.
// ----------------------------------------------------------------------------
// Rows are taken one word per cycle; a row whose index is at or above the node
// count is dropped. The row of the last node in use starts a depth-first walk,
// during which no row is accepted. The walk takes each start node in ST_FIND,
// then alternates ST_READ, a registered read of the adjacency row at the stack
// top, and ST_EVAL, which pushes an unvisited neighbor or pops the top node;
// ST_FIND with no start node left closes the walk. The reverse postorder then
// leaves through an output register, one node per cycle while m_tready is
// high, with tlast on the final node.
// The next row is accepted while that final node still waits to be taken.
module dfs_topological_order
	import dfs_topo_pkg::*;
#(
	parameter int MAX_NODES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [4:0]  cfg_wdata, // node_count
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // row_index [3:0], row_edges [19:4], zero [23:20]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // node_id [3:0], zero [7:4]
	output logic        m_tlast    // last_node
);

	localparam int NODES = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;

	dfs_cmd_t          cmd;
	dfs_stat_t         stat;
	logic [NODE_W-1:0] node_id;

	// Controller.
	dfs_topo_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Datapath.
	dfs_topo_dp #(
		.NODES(NODES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.row_index(s_tdata[NODE_W-1:0]),
		.row_edges(s_tdata[NODE_W+ROW_W-1:NODE_W]),
		.cmd      (cmd),
		.stat     (stat),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.node_id  (node_id),
		.last_node(m_tlast)
	);

	// Result word packing.
	assign m_tdata = {4'b0000, node_id};

endmodule
